### rtl/core/ssosc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ssosc_pkg;

	localparam int SineTableBitsDefault = 10;
	localparam int SampleBitsDefault    = 16;

	localparam int ActionW = 4;
	localparam int ValueW  = 32;
	localparam int AmpW    = 16;
	localparam int FreqW   = 31;
	localparam int AngleW  = 32;
	localparam int DivW    = 13;
	localparam int CfgIdxW = 2;
	localparam int CfgW    = 32;

	// action codes
	localparam logic [ActionW-1:0] ACT_TICK        = 4'd0;
	localparam logic [ActionW-1:0] ACT_TARGET_FREQ = 4'd1;
	localparam logic [ActionW-1:0] ACT_TARGET_AMP  = 4'd2;
	localparam logic [ActionW-1:0] ACT_FORCE_AMP   = 4'd3;
	localparam logic [ActionW-1:0] ACT_SET_PHASE   = 4'd4;
	localparam logic [ActionW-1:0] ACT_REWIND      = 4'd5;
	localparam logic [ActionW-1:0] ACT_FORCE_PHASE = 4'd6;
	localparam logic [ActionW-1:0] ACT_SHIFT       = 4'd7;
	localparam logic [ActionW-1:0] ACT_RESTART     = 4'd8;

	// config register indexes
	localparam logic [CfgIdxW-1:0] REG_DIVISOR  = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_INIT_FRQ = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_INIT_AMP = 2'd2;
	localparam logic [CfgIdxW-1:0] REG_INIT_PHS = 2'd3;

	localparam logic [DivW-1:0]   DIVISOR_RESET  = 13'd512;
	localparam logic [AmpW-1:0]   INIT_AMP_RESET = 16'd16384;

	localparam longint unsigned HalfPiQ30 = 64'd1686629713;
	localparam longint unsigned OneQ30    = 64'd1073741824;

	// quarter-wave entry: taylor series in q30, scaled to 2^(sb-1)-1
	// term k is divided by (2k)(2k+1), signs alternate starting with minus
	function automatic longint sine_entry(input int i, input int tb, input int sb);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint          sum;
		longint          m;
		longint          v;
		x    = (HalfPiQ30 * longint'(i)) >> tb;
		x2   = (x * x) >> 30;
		term = x;
		sum  = longint'(x);
		m    = (longint'(1) <<< (sb - 1)) - 1;
		term = ((term * x2) >> 30) / 64'd6;   sum = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd20;  sum = sum + longint'(term);
		term = ((term * x2) >> 30) / 64'd42;  sum = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd72;  sum = sum + longint'(term);
		term = ((term * x2) >> 30) / 64'd110; sum = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd156; sum = sum + longint'(term);
		term = ((term * x2) >> 30) / 64'd210; sum = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd272; sum = sum + longint'(term);
		term = ((term * x2) >> 30) / 64'd342; sum = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd420; sum = sum + longint'(term);
		term = ((term * x2) >> 30) / 64'd506; sum = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd600; sum = sum + longint'(term);
		if (sum < 0) sum = 0;
		if (sum > longint'(OneQ30)) sum = longint'(OneQ30);
		v = (sum * m + (longint'(1) <<< 29)) >>> 30;
		if (v > m) v = m;
		return v;
	endfunction

endpackage
`default_nettype wire

### rtl/core/ssosc_sine_rom.sv
`timescale 1ns / 1ps
`default_nettype none
module ssosc_sine_rom import ssosc_pkg::*; #(
	parameter int SINE_TABLE_BITS = SineTableBitsDefault,
	parameter int SAMPLE_BITS     = SampleBitsDefault
) (
	input  wire logic                       clk,
	input  wire logic [SINE_TABLE_BITS:0]   addr,
	output logic      [SAMPLE_BITS-2:0]     data
);

	localparam int Depth = (1 << SINE_TABLE_BITS) + 1;

	logic [SAMPLE_BITS-2:0] rom [Depth];

	for (genvar g = 0; g < Depth; g++) begin : g_rom
		localparam longint Entry = sine_entry(g, SINE_TABLE_BITS, SAMPLE_BITS);
		assign rom[g] = Entry[SAMPLE_BITS-2:0];
	end

	// registered read
	always_ff @(posedge clk) begin
		data <= rom[addr];
	end

endmodule
`default_nettype wire

### rtl/core/smoothed_sine_oscillator_core.sv
`timescale 1ns / 1ps
`default_nettype none
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_ready   | action, value
// out     | output    | out_valid / out_ready | sample, current_amplitude,
//         |           |                       | current_frequency, current_angle, current_phase
// cfg     | input     | cfg_we (no wait)      | cfg_index, cfg_data
//
// one beat at a time: in_ready is high only while the sequencer is idle
// tick steps through rom read, multiply, advance, then two
// 32-step glide divisions on the shared restoring divider,
// a result state and the idle state
// target actions run one glide plus lookup, other actions only the lookup
// a result that is not taken holds the sequencer in its last state
// asynchronous active-low reset clears state and loads register defaults
module smoothed_sine_oscillator_core import ssosc_pkg::*; #(
	parameter int SINE_TABLE_BITS = SineTableBitsDefault,
	parameter int SAMPLE_BITS     = SampleBitsDefault
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [ActionW-1:0]        action,
	input  wire logic signed [ValueW-1:0]  value,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic signed [AmpW-1:0]         sample,
	output logic signed [AmpW-1:0]         current_amplitude,
	output logic [FreqW-1:0]               current_frequency,
	output logic [AngleW-1:0]              current_angle,
	output logic [AngleW-1:0]              current_phase,
	input  wire logic                      cfg_we,
	input  wire logic [CfgIdxW-1:0]        cfg_index,
	input  wire logic [CfgW-1:0]           cfg_data
);

	localparam int TB  = SINE_TABLE_BITS;
	localparam int SB  = SAMPLE_BITS;
	localparam int DW  = 33; // signed difference width

	// sequencer states
	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_APPLY  = 4'd1;
	localparam logic [3:0] ST_LOOK   = 4'd2;
	localparam logic [3:0] ST_MUL    = 4'd3;
	localparam logic [3:0] ST_ADV    = 4'd4;
	localparam logic [3:0] ST_DSTART = 4'd5;
	localparam logic [3:0] ST_DIV    = 4'd6;
	localparam logic [3:0] ST_DEND   = 4'd7;
	localparam logic [3:0] ST_OUT    = 4'd8;

	logic [3:0] state_q;

	// config registers
	logic [DivW-1:0]          divisor_q;
	logic [FreqW-1:0]         init_freq_q;
	logic signed [AmpW-1:0]   init_amp_q;
	logic [AngleW-1:0]        init_phase_q;

	// oscillator state
	logic signed [AmpW-1:0]   amp_now_q, amp_goal_q;
	logic [FreqW-1:0]         freq_now_q, freq_goal_q;
	logic [AngleW-1:0]        angle_q, phase_q;

	// captured beat
	logic [ActionW-1:0]       act_q;
	logic [ValueW-1:0]        val_q;

	// glide unit
	logic                     sel_amp_q;   // 0 glide frequency, 1 glide amplitude
	logic                     neg_q;
	logic                     nz_q;
	logic [AngleW-1:0]        quo_q;
	logic [DivW:0]            rem_q;
	logic [4:0]               cnt_q;

	// sample path
	logic                     quad_hi_q;
	logic signed [AmpW-1:0]   sample_q;
	logic [TB:0]              rom_addr;
	logic [SB-2:0]            rom_data;

	ssosc_sine_rom #(
		.SINE_TABLE_BITS(SINE_TABLE_BITS),
		.SAMPLE_BITS    (SAMPLE_BITS)
	) u_rom (
		.clk (clk),
		.addr(rom_addr),
		.data(rom_data)
	);

	// quadrant folding: odd quadrants mirror the index
	logic [TB-1:0] idx;
	assign idx = angle_q[AngleW-3 -: TB];
	always_comb begin
		if (angle_q[AngleW-2]) rom_addr = (TB+1)'(1 << TB) - {1'b0, idx};
		else                   rom_addr = {1'b0, idx};
	end

	// magnitude multiply, truncation toward zero, sign applied last
	logic [AmpW:0]        amp_mag;
	logic [AmpW+SB-1:0]   prod;
	logic [AmpW:0]        prod_mag;
	logic                 prod_neg;
	logic signed [AmpW:0] prod_s;
	always_comb begin
		amp_mag  = amp_now_q[AmpW-1] ? (AmpW+1)'(-{amp_now_q[AmpW-1], amp_now_q})
		                             : {1'b0, amp_now_q};
		prod     = (AmpW+SB)'(amp_mag) * (AmpW+SB)'(rom_data);
		prod_mag = prod[SB-1 +: AmpW+1];
		prod_neg = amp_now_q[AmpW-1] ^ quad_hi_q;
		prod_s   = prod_neg ? -$signed(prod_mag) : $signed(prod_mag);
	end

	// value operand views
	logic signed [AmpW-1:0] val_sat16;
	logic [FreqW-1:0]       val_freq;
	always_comb begin
		if ($signed(val_q) > 32'sd32767)       val_sat16 = 16'sh7FFF;
		else if ($signed(val_q) < -32'sd32768) val_sat16 = 16'sh8000;
		else                                   val_sat16 = val_q[AmpW-1:0];
		val_freq = val_q[ValueW-1] ? '0 : val_q[FreqW-1:0];
	end

	// glide operands for the selected quantity
	logic signed [DW-1:0] g_now, g_goal, g_diff;
	logic [AngleW-1:0]    diff_mag;
	always_comb begin
		if (sel_amp_q) begin
			g_now  = DW'(amp_now_q);
			g_goal = DW'(amp_goal_q);
		end else begin
			g_now  = $signed({2'b00, freq_now_q});
			g_goal = $signed({2'b00, freq_goal_q});
		end
		g_diff   = g_goal - g_now;
		diff_mag = g_diff[DW-1] ? AngleW'(-g_diff) : g_diff[AngleW-1:0];
	end

	// restoring division step, divisor zero acts as one
	logic [DivW-1:0] div_eff;
	logic [DivW:0]   rem_sh;
	logic            rem_ge;
	assign div_eff = (divisor_q == '0) ? DivW'(1) : divisor_q;
	assign rem_sh  = {rem_q[DivW-1:0], quo_q[AngleW-1]};
	assign rem_ge  = rem_sh >= {1'b0, div_eff};

	// glide result: quotient, at least one unit toward the goal
	logic [AngleW-1:0]    step_mag;
	logic signed [DW-1:0] g_new;
	always_comb begin
		step_mag = (quo_q == '0 && nz_q) ? AngleW'(1) : quo_q;
		g_new    = neg_q ? g_now - $signed({1'b0, step_mag})
		                 : g_now + $signed({1'b0, step_mag});
	end

	assign in_ready = (state_q == ST_IDLE);

	// config port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			divisor_q    <= DIVISOR_RESET;
			init_freq_q  <= '0;
			init_amp_q   <= INIT_AMP_RESET;
			init_phase_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DIVISOR:  divisor_q    <= cfg_data[DivW-1:0];
				REG_INIT_FRQ: init_freq_q  <= cfg_data[FreqW-1:0];
				REG_INIT_AMP: init_amp_q   <= cfg_data[AmpW-1:0];
				REG_INIT_PHS: init_phase_q <= cfg_data[AngleW-1:0];
				default: ;
			endcase
		end
	end

	// sequencer and datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			amp_now_q   <= '0;
			amp_goal_q  <= '0;
			freq_now_q  <= '0;
			freq_goal_q <= '0;
			angle_q     <= '0;
			phase_q     <= '0;
			out_valid   <= 1'b0;
			sel_amp_q   <= 1'b0;
			cnt_q       <= '0;
		end else begin
			// a taken beat is refilled in the result state, cleared elsewhere
			if (out_valid && out_ready && state_q != ST_OUT) out_valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						act_q   <= action;
						val_q   <= value;
						state_q <= (action == ACT_TICK) ? ST_LOOK : ST_APPLY;
					end
				end
				ST_APPLY: begin
					state_q <= (act_q inside {ACT_TARGET_FREQ, ACT_TARGET_AMP}) ?
					           ST_DSTART : ST_LOOK;
					case (act_q)
						ACT_TARGET_FREQ: begin
							freq_goal_q <= val_freq;
							sel_amp_q   <= 1'b0;
						end
						ACT_TARGET_AMP: begin
							amp_goal_q <= val_sat16;
							sel_amp_q  <= 1'b1;
						end
						ACT_FORCE_AMP: amp_now_q <= val_sat16;
						ACT_SET_PHASE: begin
							angle_q <= angle_q + (val_q - phase_q);
							phase_q <= val_q;
						end
						ACT_REWIND: angle_q <= phase_q;
						ACT_FORCE_PHASE: begin
							angle_q <= val_q;
							phase_q <= val_q;
						end
						ACT_SHIFT: begin
							angle_q <= angle_q + val_q;
							phase_q <= phase_q + val_q;
						end
						ACT_RESTART: begin
							freq_now_q  <= init_freq_q;
							freq_goal_q <= init_freq_q;
							amp_now_q   <= init_amp_q;
							amp_goal_q  <= init_amp_q;
							angle_q     <= init_phase_q;
							phase_q     <= init_phase_q;
						end
						default: ;
					endcase
				end
				ST_LOOK: begin
					// rom address settles from angle, read registered here
					quad_hi_q <= angle_q[AngleW-1];
					state_q   <= ST_MUL;
				end
				ST_MUL: begin
					if (prod_s > 17'sd32767)       sample_q <= 16'sh7FFF;
					else if (prod_s < -17'sd32768) sample_q <= 16'sh8000;
					else                           sample_q <= prod_s[AmpW-1:0];
					state_q <= (act_q == ACT_TICK) ? ST_ADV : ST_OUT;
				end
				ST_ADV: begin
					angle_q   <= angle_q + {1'b0, freq_now_q};
					sel_amp_q <= 1'b0;
					state_q   <= ST_DSTART;
				end
				ST_DSTART: begin
					neg_q   <= g_diff[DW-1];
					nz_q    <= (g_diff != '0);
					quo_q   <= diff_mag;
					rem_q   <= '0;
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					rem_q <= rem_ge ? rem_sh - {1'b0, div_eff} : rem_sh;
					quo_q <= {quo_q[AngleW-2:0], rem_ge};
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) state_q <= ST_DEND;
				end
				ST_DEND: begin
					if (sel_amp_q) amp_now_q  <= g_new[AmpW-1:0];
					else           freq_now_q <= g_new[FreqW-1:0];
					if (act_q == ACT_TICK) begin
						if (!sel_amp_q) begin
							sel_amp_q <= 1'b1;
							state_q   <= ST_DSTART;
						end else begin
							state_q <= ST_OUT;
						end
					end else begin
						state_q <= ST_LOOK;
					end
				end
				ST_OUT: begin
					if (!out_valid || out_ready) begin
						sample            <= sample_q;
						current_amplitude <= amp_now_q;
						current_frequency <= freq_now_q;
						current_angle     <= angle_q;
						current_phase     <= phase_q;
						out_valid         <= 1'b1;
						state_q           <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

### tb/sv/tb_smoothed_sine_oscillator_core.sv
`timescale 1ns / 1ps
module tb_smoothed_sine_oscillator_core;
	import ssosc_pkg::*;

	localparam int TabBits  = 10;
	localparam int QuarterN = 1 << TabBits;
	localparam int Watchdog = 20000;

	// directed stimulus row: expected fields valid only when has_exp is set
	typedef struct {
		logic [ActionW-1:0] act;
		logic [31:0]        val;
		bit                 has_exp;
		logic [AmpW-1:0]    e_amp;
		logic [FreqW-1:0]   e_frq;
		logic [AngleW-1:0]  e_ang;
		logic [AngleW-1:0]  e_phs;
	} dir_row_t;

	typedef struct {
		logic [AmpW-1:0]   smp;
		logic [AmpW-1:0]   amp;
		logic [FreqW-1:0]  frq;
		logic [AngleW-1:0] ang;
		logic [AngleW-1:0] phs;
	} osc_out_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [ActionW-1:0] action = '0;
	logic signed [ValueW-1:0] value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [AmpW-1:0] sample;
	logic signed [AmpW-1:0] current_amplitude;
	logic [FreqW-1:0] current_frequency;
	logic [AngleW-1:0] current_angle;
	logic [AngleW-1:0] current_phase;
	logic cfg_we = 1'b0;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [CfgW-1:0] cfg_data = '0;

	always #2 clk = ~clk;

	smoothed_sine_oscillator_core dut (.*);

	// shadow of the oscillator
	longint quarter_wave [0:QuarterN];
	longint glide_div;
	longint sh_init_frq, sh_init_amp;
	logic [31:0] sh_init_phs;
	longint amp_now, amp_goal, frq_now, frq_goal;
	logic [31:0] angle_acc, phase_ofs;

	osc_out_t expected_beats[$];
	int  errors = 0;
	int  idle_cycles = 0;
	bit  rx_quiet = 0;    // last part: no receiver stalls
	bit  rx_hold = 0;     // long receiver hold-off request

	function automatic longint sine_at(logic [31:0] a);
		int     idx;
		longint s;
		idx = (a >> (30 - TabBits)) & (QuarterN - 1);
		s = a[30] ? quarter_wave[QuarterN - idx] : quarter_wave[idx];
		return a[31] ? -s : s;
	endfunction

	function automatic longint clip16(longint v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	function automatic longint amp_times_sine();
		longint p;
		p = amp_now * sine_at(angle_acc);
		return clip16(p / 32768);   // longint division truncates toward zero
	endfunction

	function automatic longint glide_step(longint now, longint goal);
		longint diff, stp;
		diff = goal - now;
		stp = diff / glide_div;
		if (stp == 0 && diff != 0) stp = (diff > 0) ? 1 : -1;
		return now + stp;
	endfunction

	// work out one result beat and advance the shadow state
	function automatic osc_out_t osc_predict(logic [ActionW-1:0] act, logic [31:0] raw);
		osc_out_t r;
		longint   sv, smp;
		sv = longint'($signed(raw));
		if (act == ACT_TICK) begin
			smp = amp_times_sine();
			angle_acc = angle_acc + frq_now[31:0];
			frq_now = glide_step(frq_now, frq_goal);
			amp_now = glide_step(amp_now, amp_goal);
		end else begin
			case (act)
				ACT_TARGET_FREQ: begin
					frq_goal = (sv < 0) ? 0 : sv;
					frq_now = glide_step(frq_now, frq_goal);
				end
				ACT_TARGET_AMP: begin
					amp_goal = clip16(sv);
					amp_now = glide_step(amp_now, amp_goal);
				end
				ACT_FORCE_AMP: amp_now = clip16(sv);
				ACT_SET_PHASE: begin
					angle_acc = angle_acc + (raw - phase_ofs);
					phase_ofs = raw;
				end
				ACT_REWIND: angle_acc = phase_ofs;
				ACT_FORCE_PHASE: begin
					angle_acc = raw;
					phase_ofs = raw;
				end
				ACT_SHIFT: begin
					angle_acc = angle_acc + raw;
					phase_ofs = phase_ofs + raw;
				end
				ACT_RESTART: begin
					frq_now = sh_init_frq;
					frq_goal = sh_init_frq;
					amp_now = sh_init_amp;
					amp_goal = sh_init_amp;
					angle_acc = sh_init_phs;
					phase_ofs = sh_init_phs;
				end
				default: ;
			endcase
			smp = amp_times_sine();
		end
		r.smp = smp[15:0];
		r.amp = amp_now[15:0];
		r.frq = frq_now[30:0];
		r.ang = angle_acc;
		r.phs = phase_ofs;
		return r;
	endfunction

	// register write on a rising edge, shadow updated alongside
	task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] d);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_DIVISOR:  glide_div = (d[12:0] == 0) ? 1 : longint'(d[12:0]);
			REG_INIT_FRQ: sh_init_frq = longint'(d[30:0]);
			REG_INIT_AMP: sh_init_amp = longint'($signed(d[15:0]));
			REG_INIT_PHS: sh_init_phs = d;
			default: ;
		endcase
		@(negedge clk);
	endtask

	// wait until every expected beat is back, then past the longest item
	task automatic drain();
		in_valid <= 1'b0;
		while (expected_beats.size() != 0) @(negedge clk);
		repeat (100) @(negedge clk);
	endtask

	// offer one beat; optional random sender gap first
	task automatic send_beat(logic [ActionW-1:0] act, logic [31:0] raw, bit gaps);
		if (gaps && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		value <= raw;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		expected_beats.push_back(osc_predict(act, raw));
		@(negedge clk);
	endtask

	function automatic logic [31:0] rand_value(logic [ActionW-1:0] act);
		case ($urandom_range(0, 5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return $urandom_range(0, 65535) - 32768;
			3: return (act == ACT_TARGET_FREQ) ? $urandom_range(0, 1 << 26) : $urandom;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [ActionW-1:0] rand_action();
		int k;
		k = $urandom_range(0, 99);
		if (k < 45) return ACT_TICK;
		if (k < 95) return ActionW'($urandom_range(1, 8));
		return ActionW'($urandom_range(9, 15));
	endfunction

	// receiver: random stall bursts, a long hold on request
	initial begin
		int n;
		forever begin
			@(negedge clk);
			if (rx_hold) begin
				out_ready <= 1'b0;
				n = 400;
				while (n > 0) begin
					@(negedge clk);
					n--;
				end
				rx_hold = 0;
			end else if (!rx_quiet && $urandom_range(0, 7) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(negedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	// result checker at the rising edge
	always @(posedge clk) begin
		osc_out_t e;
		if (out_valid && out_ready) begin
			if (expected_beats.size() == 0) begin
				$error("unexpected result beat");
				errors++;
			end else begin
				e = expected_beats.pop_front();
				if (sample !== e.smp) begin
					$error("sample exp %0d got %0d", $signed(e.smp), sample);
					errors++;
				end
				if (current_amplitude !== e.amp) begin
					$error("current_amplitude exp %0d got %0d", $signed(e.amp),
						current_amplitude);
					errors++;
				end
				if (current_frequency !== e.frq) begin
					$error("current_frequency exp %0d got %0d", e.frq, current_frequency);
					errors++;
				end
				if (current_angle !== e.ang) begin
					$error("current_angle exp %h got %h", e.ang, current_angle);
					errors++;
				end
				if (current_phase !== e.phs) begin
					$error("current_phase exp %h got %h", e.phs, current_phase);
					errors++;
				end
			end
		end
	end

	// watchdog: cycles with no beat on either channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else if (arst_n) idle_cycles <= idle_cycles + 1;
		if (idle_cycles > Watchdog) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	dir_row_t dir_rows[$];

	initial begin
		dir_row_t row;
		for (int i = 0; i <= QuarterN; i++) quarter_wave[i] = sine_entry(i, TabBits, 16);
		glide_div = 512;
		sh_init_frq = 0;
		sh_init_amp = 16384;
		sh_init_phs = 0;
		amp_now = 0; amp_goal = 0; frq_now = 0; frq_goal = 0;
		angle_acc = 0; phase_ofs = 0;

		// directed rows: state read off directly where obvious
		dir_rows = '{
			'{ACT_TICK, 32'd0, 1, 16'd0, 31'd0, 32'd0, 32'd0},          // all zero after reset
			'{ACT_RESTART, 32'd0, 1, 16'd16384, 31'd0, 32'd0, 32'd0},   // default registers
			'{ACT_FORCE_PHASE, 32'hFFFF_FFFF, 1, 16'd16384, 31'd0, 32'hFFFF_FFFF,
				32'hFFFF_FFFF},
			'{ACT_SHIFT, 32'd1, 1, 16'd16384, 31'd0, 32'd0, 32'd0},     // wraps
			'{ACT_SET_PHASE, 32'h4000_0000, 1, 16'd16384, 31'd0, 32'h4000_0000,
				32'h4000_0000},
			'{ACT_FORCE_AMP, 32'h7FFF_FFFF, 1, 16'h7FFF, 31'd0, 32'h4000_0000,
				32'h4000_0000},                                          // saturate high
			'{ACT_FORCE_AMP, 32'h8000_0000, 1, 16'h8000, 31'd0, 32'h4000_0000,
				32'h4000_0000},                                          // saturate low
			'{ACT_TARGET_FREQ, 32'h8000_0000, 1, 16'h8000, 31'd0, 32'h4000_0000,
				32'h4000_0000},                                          // clamp to zero
			'{ACT_TICK, 32'd0, 0, '0, '0, '0, '0},  // glides away from forced amplitude
			'{ACT_TARGET_FREQ, 32'h7FFF_FFFF, 0, '0, '0, '0, '0},
			'{ACT_TARGET_AMP, 32'h7FFF_FFFF, 0, '0, '0, '0, '0},
			'{ACT_TICK, 32'd0, 0, '0, '0, '0, '0},
			'{ACT_TICK, 32'd0, 0, '0, '0, '0, '0},
			'{ACT_REWIND, 32'd0, 0, '0, '0, '0, '0},
			'{ACT_TARGET_AMP, 32'hFFFF_0000, 0, '0, '0, '0, '0},
			'{ACT_SHIFT, 32'h8000_0000, 0, '0, '0, '0, '0},
			'{ACT_TICK, 32'hFFFF_FFFF, 0, '0, '0, '0, '0},
			'{4'd9, 32'h1234_5678, 0, '0, '0, '0, '0},    // unused codes do nothing
			'{4'd15, 32'hFFFF_FFFF, 0, '0, '0, '0, '0}
		};

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			send_beat(row.act, row.val, 0);
			if (row.has_exp) begin
				// replace prediction's state fields with the literal ones
				expected_beats[$].amp = row.e_amp;
				expected_beats[$].frq = row.e_frq;
				expected_beats[$].ang = row.e_ang;
				expected_beats[$].phs = row.e_phs;
			end
		end
		drain();

		// divisor zero means jump in one step; then extremes and random settings
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					write_reg(REG_DIVISOR, 32'd0);
					write_reg(REG_INIT_FRQ, 32'h7FFF_FFFF);
					write_reg(REG_INIT_AMP, 32'h0000_8000);
					write_reg(REG_INIT_PHS, 32'hFFFF_FFFF);
				end
				1: begin
					write_reg(REG_DIVISOR, 32'd4096);
					write_reg(REG_INIT_FRQ, 32'd0);
					write_reg(REG_INIT_AMP, 32'h0000_7FFF);
					write_reg(REG_INIT_PHS, 32'd0);
				end
				2: begin
					write_reg(REG_DIVISOR, 32'd1);
					write_reg(REG_INIT_FRQ, 32'h0100_0000);
				end
				3: write_reg(REG_DIVISOR, 32'h1FFF);   // widest field value
				default: begin
					write_reg(REG_DIVISOR, $urandom_range(1, 16));
					write_reg(REG_INIT_FRQ, $urandom);
					write_reg(REG_INIT_AMP, $urandom);
					write_reg(REG_INIT_PHS, $urandom);
				end
			endcase
			send_beat(ACT_RESTART, $urandom, 0);
			if (ph == 2) rx_hold = 1;   // long receiver hold: the sender stalls while the output backs up
			if (ph == 5) rx_quiet = 1;
			repeat (100) begin
				logic [ActionW-1:0] a;
				a = rand_action();
				send_beat(a, rand_value(a), !rx_quiet);
			end
			drain();
		end

		if (errors == 0) $display("Regression PASS");
		else $display("Regression FAIL");
		$finish;
	end
endmodule
